>>> design/ctb_pkg.sv
// Shared types and constants for the countdown timer bank.
// Used by ctb_in_reg, ctb_timer_core and countdown_timer_bank.
`default_nettype none

package ctb_pkg;

    // Timer layout: seconds timers occupy the lowest ids, fast timers follow.
    localparam int NumSec    = 2;
    localparam int NumFast   = 3;
    localparam int NumTimers = NumSec + NumFast;

    localparam int SecW   = 8;
    localparam int FastW  = 15;
    localparam int PreW   = 8;
    localparam int IdW    = 3;
    localparam int ValW   = 16;
    localparam int TpsW   = 8;
    localparam int FastIdxW = 2;

    localparam logic [TpsW-1:0] TpsReset = 8'd100;

    // Stream payload widths, padded to whole bytes.
    localparam int InTdataW  = 24;
    localparam int OutTdataW = 8;

    typedef enum logic {
        OP_TICK = 1'b0,
        OP_LOAD = 1'b1
    } t_opcode;

    typedef struct packed {
        t_opcode              opcode;
        logic [IdW-1:0]       counter_id;
        logic [ValW-1:0]      load_value;
    } t_item;

    typedef struct packed {
        logic [NumTimers-1:0] done_flags;
        logic                 selected_done;
    } t_result;

endpackage

`default_nettype wire

>>> design/countdown_timer_bank.sv
// Top level of the countdown timer bank: input stage, timer core, result register.
// Depends on ctb_pkg, ctb_in_reg and ctb_timer_core.
//
//  Channel   Direction  Payload
//  s_axis    in         tuser: opcode; tdata: counter_id, load_value
//  m_axis    out        tdata: done_flags, selected_done
//  cfg       in         i_cfg_wdata: ticks_per_second
//
// Every item passes input register -> timer logic -> result register, and a new item
// is taken every cycle while results are drained.
// The timer state updates when an item moves into the result register.
// A stall on m_axis holds the result and, once the input register is full, s_axis.
// Reset is synchronous and active low; ticks_per_second resets to 100.
`default_nettype none

module countdown_timer_bank (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    input  wire                           i_cfg_we,
    input  wire [ctb_pkg::TpsW-1:0]       i_cfg_wdata,
    input  wire                           s_axis_tvalid,
    output logic                          s_axis_tready,
    input  wire [ctb_pkg::InTdataW-1:0]   s_axis_tdata,   // [2:0] counter_id, [18:3] load_value
    input  wire                           s_axis_tuser,   // [0] opcode
    output logic                          m_axis_tvalid,
    input  wire                           m_axis_tready,
    output logic [ctb_pkg::OutTdataW-1:0] m_axis_tdata    // [4:0] done_flags, [5] selected_done
);

    logic                           w_in_valid;
    ctb_pkg::t_item                 w_item;
    ctb_pkg::t_result               w_result;
    logic [ctb_pkg::NumTimers-1:0]  w_flags;
    logic                           w_advance;
    logic                           r_out_valid;
    ctb_pkg::t_result               r_out_result;

    // An item moves on when the result register is empty or being drained.
    assign w_advance = w_in_valid && (!r_out_valid || m_axis_tready);

    ctb_in_reg u_in_reg (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .i_advance     (w_advance),
        .o_valid       (w_in_valid),
        .o_item        (w_item)
    );

    ctb_timer_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_fire      (w_advance),
        .i_item      (w_item),
        .o_result    (w_result),
        .o_flags     (w_flags)
    );

    // Result register valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (!r_out_valid || m_axis_tready) begin
            r_out_valid <= w_in_valid;
        end
    end

    // Result payload.
    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_out_result <= w_result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(ctb_pkg::OutTdataW - ctb_pkg::NumTimers - 1){1'b0}},
                            r_out_result.selected_done, r_out_result.done_flags};

    // A selected flag can only be set when some flag is set.
    a_sel_implies_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_result.selected_done) |-> (r_out_result.done_flags != '0))
        else $error("selected_done set with no done flag");

    // A load of a used timer clears its flag in the result.
    a_load_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_advance && w_item.opcode == ctb_pkg::OP_LOAD
         && w_item.counter_id < ctb_pkg::IdW'(ctb_pkg::NumTimers))
        |=> !r_out_result.done_flags[$past(w_item.counter_id)])
        else $error("load did not clear the timer flag");

    // A tick never clears a flag.
    a_tick_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_advance && w_item.opcode == ctb_pkg::OP_TICK)
        |=> ((r_out_result.done_flags & $past(w_flags)) == $past(w_flags)))
        else $error("tick cleared a sticky flag");

    // A full input register that cannot move blocks the slave side.
    a_in_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_valid && !w_advance) |-> !s_axis_tready)
        else $error("input accepted while the stage is blocked");

endmodule

`default_nettype wire

>>> design/ctb_in_reg.sv
// Input register stage of the countdown timer bank.
// Captures one transaction from the slave stream; depends on ctb_pkg.
`default_nettype none

module ctb_in_reg (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          s_axis_tvalid,
    output logic                         s_axis_tready,
    input  wire [ctb_pkg::InTdataW-1:0]  s_axis_tdata,   // [2:0] counter_id, [18:3] load_value
    input  wire                          s_axis_tuser,   // [0] opcode
    input  wire                          i_advance,
    output logic                         o_valid,
    output ctb_pkg::t_item               o_item
);

    logic           r_valid;
    ctb_pkg::t_item r_item;

    // The stage can take a new transaction when empty or when its item moves on.
    assign s_axis_tready = !r_valid || i_advance;

    // Valid flag follows the handshake.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_valid <= s_axis_tvalid;
        end
    end

    // Payload capture, no reset needed.
    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_item.opcode     <= ctb_pkg::t_opcode'(s_axis_tuser);
            r_item.counter_id <= s_axis_tdata[ctb_pkg::IdW-1:0];
            r_item.load_value <= s_axis_tdata[ctb_pkg::IdW +: ctb_pkg::ValW];
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

`default_nettype wire

>>> design/ctb_timer_core.sv
// Timer state, prescaler, configuration register and next-state logic.
// Produces the result for the item presented; depends on ctb_pkg.
`default_nettype none

module ctb_timer_core (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_cfg_we,
    input  wire [ctb_pkg::TpsW-1:0]      i_cfg_wdata,
    input  wire                          i_fire,
    input  ctb_pkg::t_item               i_item,
    output ctb_pkg::t_result             o_result,
    output logic [ctb_pkg::NumTimers-1:0] o_flags
);

    logic [ctb_pkg::TpsW-1:0]      r_tps;
    logic [ctb_pkg::PreW-1:0]      r_prescale, n_prescale;
    logic [ctb_pkg::SecW-1:0]      r_sec  [ctb_pkg::NumSec];
    logic [ctb_pkg::SecW-1:0]      n_sec  [ctb_pkg::NumSec];
    logic [ctb_pkg::FastW-1:0]     r_fast [ctb_pkg::NumFast];
    logic [ctb_pkg::FastW-1:0]     n_fast [ctb_pkg::NumFast];
    logic [ctb_pkg::NumTimers-1:0] r_done, n_done;
    logic [ctb_pkg::PreW-1:0]      w_pre_inc;
    logic [ctb_pkg::FastIdxW-1:0]  w_fast_idx;
    logic                          w_is_sec, w_is_fast;

    assign w_pre_inc  = r_prescale + 1'b1;
    assign w_is_sec   = i_item.counter_id < ctb_pkg::IdW'(ctb_pkg::NumSec);
    assign w_is_fast  = !w_is_sec
                      && (i_item.counter_id < ctb_pkg::IdW'(ctb_pkg::NumTimers));
    assign w_fast_idx = ctb_pkg::FastIdxW'(i_item.counter_id - ctb_pkg::IdW'(ctb_pkg::NumSec));

    // Next state for one item: a tick steps the timers, a load writes one.
    always_comb begin
        n_prescale = r_prescale;
        n_sec      = r_sec;
        n_fast     = r_fast;
        n_done     = r_done;
        unique case (i_item.opcode)
            ctb_pkg::OP_TICK: begin
                // Seconds timers step when the prescaler reaches the configured count.
                if (w_pre_inc == r_tps) begin
                    n_prescale = '0;
                    for (int i = 0; i < ctb_pkg::NumSec; i++) begin
                        if (r_sec[i] != '0) begin
                            n_sec[i] = r_sec[i] - 1'b1;
                        end else begin
                            n_done[i] = 1'b1;
                        end
                    end
                end else begin
                    n_prescale = w_pre_inc;
                end
                // Fast timers step on every tick.
                for (int i = 0; i < ctb_pkg::NumFast; i++) begin
                    if (r_fast[i] != '0) begin
                        n_fast[i] = r_fast[i] - 1'b1;
                    end else begin
                        n_done[i + ctb_pkg::NumSec] = 1'b1;
                    end
                end
            end
            ctb_pkg::OP_LOAD: begin
                // Seconds timers keep the low byte, fast timers take half the value.
                if (w_is_sec) begin
                    n_sec[i_item.counter_id[0]] = i_item.load_value[ctb_pkg::SecW-1:0];
                    n_done[i_item.counter_id]   = 1'b0;
                end else if (w_is_fast) begin
                    n_fast[w_fast_idx]        = i_item.load_value[ctb_pkg::ValW-1:1];
                    n_done[i_item.counter_id] = 1'b0;
                end
            end
            default: begin
                n_prescale = r_prescale;
            end
        endcase
    end

    // Result for the item: all flags plus the flag of the named timer.
    always_comb begin
        o_result.done_flags    = n_done;
        o_result.selected_done = (w_is_sec || w_is_fast) ? n_done[i_item.counter_id] : 1'b0;
    end

    assign o_flags = r_done;

    // Configuration register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tps <= ctb_pkg::TpsReset;
        end else if (i_cfg_we) begin
            r_tps <= i_cfg_wdata;
        end
    end

    // Timer state updates once per accepted item.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prescale <= '0;
            r_done     <= '0;
            for (int i = 0; i < ctb_pkg::NumSec; i++) begin
                r_sec[i] <= '0;
            end
            for (int i = 0; i < ctb_pkg::NumFast; i++) begin
                r_fast[i] <= '0;
            end
        end else if (i_fire) begin
            r_prescale <= n_prescale;
            r_done     <= n_done;
            r_sec      <= n_sec;
            r_fast     <= n_fast;
        end
    end

endmodule

`default_nettype wire

>>> verif/tb_top.sv
// Self-checking testbench for countdown_timer_bank: random and directed tick/load traffic
// with a class-based scoreboard that predicts the done flags. Depends on ctb_pkg and the RTL.
`timescale 1ns / 100ps

module tb_top;

    localparam int StallLimit  = 1000;  // cycles without any transaction before giving up
    localparam int LongHold    = 64;    // one long receiver stall to back up the input side
    localparam int HoldAtCount = 120;   // result count at which the long stall starts
    localparam int DrainCycles = 6;     // settle time before a register write and at the end

    // Scoreboard: keeps its own copy of the timer bank and the expected flag results.
    class timer_scoreboard;
        logic [ctb_pkg::TpsW-1:0]      tps;
        logic [ctb_pkg::PreW-1:0]      prescale;
        logic [ctb_pkg::SecW-1:0]      sec_count [ctb_pkg::NumSec];
        logic [ctb_pkg::FastW-1:0]     fast_count [ctb_pkg::NumFast];
        logic [ctb_pkg::NumTimers-1:0] done;
        ctb_pkg::t_result              flags_q[$];
        int                            mismatches;

        function new();
            tps      = ctb_pkg::TpsReset;
            prescale = '0;
            done     = '0;
            foreach (sec_count[i]) sec_count[i] = '0;
            foreach (fast_count[i]) fast_count[i] = '0;
            mismatches = 0;
        endfunction

        // Applies one accepted transaction and queues the flags it should produce.
        function void note_item(ctb_pkg::t_item it);
            ctb_pkg::t_result want;
            if (it.opcode == ctb_pkg::OP_TICK) begin
                prescale = prescale + 1'b1;
                if (prescale == tps) begin
                    prescale = '0;
                    for (int i = 0; i < ctb_pkg::NumSec; i++) begin
                        if (sec_count[i] != 0) sec_count[i] = sec_count[i] - 1'b1;
                        else done[i] = 1'b1;
                    end
                end
                for (int i = 0; i < ctb_pkg::NumFast; i++) begin
                    if (fast_count[i] != 0) fast_count[i] = fast_count[i] - 1'b1;
                    else done[ctb_pkg::NumSec + i] = 1'b1;
                end
            end else if (it.counter_id < ctb_pkg::NumSec) begin
                sec_count[it.counter_id] = it.load_value[ctb_pkg::SecW-1:0];
                done[it.counter_id] = 1'b0;
            end else if (it.counter_id < ctb_pkg::NumTimers) begin
                fast_count[it.counter_id - ctb_pkg::NumSec] = it.load_value[ctb_pkg::ValW-1:1];
                done[it.counter_id] = 1'b0;
            end
            want.done_flags    = done;
            want.selected_done = (it.counter_id < ctb_pkg::NumTimers) ?
                                 done[it.counter_id] : 1'b0;
            flags_q.push_back(want);
        endfunction

        // Compares one accepted result with the oldest expectation.
        function void check_flags(logic [ctb_pkg::OutTdataW-1:0] data);
            ctb_pkg::t_result want;
            ctb_pkg::t_result got;
            got.done_flags    = data[ctb_pkg::NumTimers-1:0];
            got.selected_done = data[ctb_pkg::NumTimers];
            if (flags_q.size() == 0) begin
                if (mismatches < 10)
                    $display("Unexpected result: done_flags=%b selected_done=%b",
                             got.done_flags, got.selected_done);
                mismatches++;
            end else begin
                want = flags_q.pop_front();
                if (got.done_flags !== want.done_flags ||
                    got.selected_done !== want.selected_done) begin
                    if (mismatches < 10)
                        $display("Mismatch: done_flags exp=%b act=%b, selected exp=%b act=%b",
                                 want.done_flags, got.done_flags,
                                 want.selected_done, got.selected_done);
                    mismatches++;
                end
            end
        endfunction

        function int pending();
            return flags_q.size();
        endfunction
    endclass

    logic                          i_clk = 1'b0;
    logic                          i_rst_n = 1'b0;
    logic                          cfg_we = 1'b0;
    logic [ctb_pkg::TpsW-1:0]      cfg_wdata = '0;
    logic                          in_valid = 1'b0;
    logic [ctb_pkg::InTdataW-1:0]  in_data = '0;
    logic                          in_user = 1'b0;
    logic                          out_ready = 1'b0;
    logic                          in_ready;
    logic                          out_valid;
    logic [ctb_pkg::OutTdataW-1:0] out_data;

    // When set, neither side inserts idle cycles.
    bit                   calm = 1'b0;
    int                   idle_cycles = 0;
    timer_scoreboard      sb = new();

    always #10 i_clk = ~i_clk;

    countdown_timer_bank u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (cfg_we),
        .i_cfg_wdata   (cfg_wdata),
        .s_axis_tvalid (in_valid),
        .s_axis_tready (in_ready),
        .s_axis_tdata  (in_data),
        .s_axis_tuser  (in_user),
        .m_axis_tvalid (out_valid),
        .m_axis_tready (out_ready),
        .m_axis_tdata  (out_data)
    );

    // Watchdog: ends the run if no transaction happens on either side for too long.
    always @(posedge i_clk) begin
        if ((in_valid && in_ready === 1'b1) || (out_valid === 1'b1 && out_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles == StallLimit) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    function automatic ctb_pkg::t_item make_item(ctb_pkg::t_opcode op, int id, int value);
        ctb_pkg::t_item it;
        it.opcode     = op;
        it.counter_id = ctb_pkg::IdW'(id);
        it.load_value = ctb_pkg::ValW'(value);
        return it;
    endfunction

    // Mostly small load values so timers expire often; a quarter use the full range.
    function automatic ctb_pkg::t_item random_item(int tick_pct);
        ctb_pkg::t_item it;
        it.opcode     = ($urandom_range(99, 0) < tick_pct) ? ctb_pkg::OP_TICK : ctb_pkg::OP_LOAD;
        it.counter_id = ctb_pkg::IdW'($urandom_range(7, 0));
        if ($urandom_range(3, 0) == 0) it.load_value = ctb_pkg::ValW'($urandom);
        else it.load_value = ctb_pkg::ValW'($urandom_range(15, 0));
        return it;
    endfunction

    // Offers one transaction after a random gap and records it once accepted.
    task automatic send(input ctb_pkg::t_item it);
        int gap;
        gap = calm ? 0 : $urandom_range(15, 0);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_data  <= {{(ctb_pkg::InTdataW - ctb_pkg::ValW - ctb_pkg::IdW){1'b0}},
                     it.load_value, it.counter_id};
        in_user  <= it.opcode;
        do @(posedge i_clk); while (in_ready !== 1'b1);
        sb.note_item(it);
    endtask

    task automatic run_phase(input int count, input int tick_pct);
        repeat (count) send(random_item(tick_pct));
    endtask

    // Stops offering and waits until every expected result has come back.
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DrainCycles) @(posedge i_clk);
    endtask

    task automatic write_tps(input logic [ctb_pkg::TpsW-1:0] value);
        wait_idle();
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge i_clk);
        cfg_we <= 1'b0;
        sb.tps = value;
    endtask

    // Result side: random back-pressure plus one long hold to fill the pipeline.
    initial begin
        int gap;
        int taken;
        taken = 0;
        while (i_rst_n !== 1'b1) @(posedge i_clk);
        forever begin
            gap = calm ? 0 : $urandom_range(15, 0);
            if (taken == HoldAtCount) gap = LongHold;
            if (gap > 0) begin
                out_ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            out_ready <= 1'b1;
            do @(posedge i_clk); while (out_valid !== 1'b1);
            sb.check_flags(out_data);
            taken++;
        end
    end

    // Stimulus sequence.
    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part at the reset rate: first tick on idle timers sets the fast flags.
        send(make_item(ctb_pkg::OP_TICK, 0, 0));
        send(make_item(ctb_pkg::OP_TICK, 7, 16'hFFFF));
        send(make_item(ctb_pkg::OP_LOAD, 0, 16'hFFFF));
        send(make_item(ctb_pkg::OP_LOAD, 1, 16'h0100));
        send(make_item(ctb_pkg::OP_LOAD, 2, 16'hFFFF));
        send(make_item(ctb_pkg::OP_LOAD, 3, 1));
        send(make_item(ctb_pkg::OP_LOAD, 4, 3));
        // Loads to unused ids change nothing and report not done.
        send(make_item(ctb_pkg::OP_LOAD, 5, 16'hFFFF));
        send(make_item(ctb_pkg::OP_LOAD, 6, 0));
        send(make_item(ctb_pkg::OP_LOAD, 7, 16'h5A5A));
        // Ticks select the reported flag by id and ignore the value.
        for (int i = 0; i < 8; i++)
            send(make_item(ctb_pkg::OP_TICK, i, (i % 2) ? 16'hAAAA : 16'h5555));
        send(make_item(ctb_pkg::OP_LOAD, 2, 0));
        send(make_item(ctb_pkg::OP_LOAD, 3, 16'hAAAA));
        send(make_item(ctb_pkg::OP_LOAD, 4, 16'h5555));
        send(make_item(ctb_pkg::OP_TICK, 2, 16'hFFFF));
        send(make_item(ctb_pkg::OP_TICK, 4, 0));

        // Seconds timers step on every tick.
        write_tps(8'd1);
        run_phase(70, 70);

        write_tps(8'd255);
        run_phase(60, 60);

        // A rate of zero steps once every 256 ticks; this stretch runs without idling.
        calm = 1'b1;
        write_tps(8'd0);
        run_phase(80, 70);
        calm = 1'b0;

        // Push the prescaler high, then lower the rate below its count.
        write_tps(8'd250);
        while (sb.prescale < 150) send(random_item(100));
        write_tps(8'd3);
        run_phase(130, 85);

        write_tps(ctb_pkg::TpsW'($urandom_range(255, 1)));
        run_phase(70, 65);

        write_tps(8'd2);
        run_phase(60, 70);

        wait_idle();
        repeat (DrainCycles) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
